/* design/plst_pkg.sv */
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and constants for the positional list store.
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 8;
  localparam int LEN_W        = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_FINISH
  } state_t;

endpackage

/* design/plst_ram.sv */
// ----------------------------------------------------------------------------
// plst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module plst_ram #(
  parameter int WIDTH = plst_pkg::VALUE_W,
  parameter int DEPTH = plst_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/positional_list_store_unit.sv */
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Bounded ordered list of signed values with insert, delete, length query and
// clear by 1-based position.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// Exactly one result (status, length) follows, shown for a single cycle with
// done high. The receiver cannot stall and must take it then. Length query,
// clear and every rejected request (full, empty, no such position) raise done
// in the cycle right after the request is taken, and busy stays low. An
// accepted insert or delete moves the entries behind the position one slot at
// a time through the list RAM, one entry per cycle behind a registered read.
// Its done is registered in S_FINISH, which follows S_SHIFT once the last of
// the entries moved (at most CAPACITY - 1) is written. When nothing moves,
// the request still passes through S_SHIFT and S_FINISH. busy stays high from
// the accepting edge until the cycle that shows done.
module positional_list_store_unit #(
  parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             func,
  input  logic signed [plst_pkg::VALUE_W-1:0]    value,
  input  logic [plst_pkg::POS_W-1:0]             position,
  output logic                                   done,
  output logic [1:0]                             status,
  output logic [plst_pkg::LEN_W-1:0]             length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W) + 1;

  plst_pkg::state_t state, state_next;

  logic [CW-1:0]                  count, count_next;
  logic                           is_ins, is_ins_next;
  logic [AW-1:0]                  rd_addr, rd_addr_next;
  logic [CW-1:0]                  left, left_next;
  logic                           pend, pend_next;
  logic [AW-1:0]                  pend_addr, pend_addr_next;
  logic [AW-1:0]                  idx, idx_next;
  logic [plst_pkg::VALUE_W-1:0]   val, val_next;
  logic                           done_next;
  logic [1:0]                     status_next;
  logic [plst_pkg::LEN_W-1:0]     length_next;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [plst_pkg::VALUE_W-1:0]   ram_wdata;
  logic [plst_pkg::VALUE_W-1:0]   ram_rdata;

  logic [XW-1:0] pos_x, cnt_x, ins_idx_x, ins_n_x, del_n_x;
  logic          accept, ins_ok, del_ok;

  assign busy   = (state != plst_pkg::S_IDLE);
  assign accept = start && !busy;

  assign pos_x = XW'(position);
  assign cnt_x = XW'(count);

  always_comb begin
    ins_idx_x = (position == '0) ? '0 : pos_x - XW'(1);
    if (ins_idx_x > cnt_x) begin
      ins_idx_x = cnt_x;
    end
  end

  assign ins_n_x = cnt_x - ins_idx_x;
  assign del_n_x = cnt_x - pos_x;
  assign ins_ok  = (cnt_x < XW'(CAPACITY));
  assign del_ok  = (count != '0) && (position != '0) && (pos_x <= cnt_x);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      plst_pkg::S_IDLE: begin
        if (accept) begin
          if ((plst_pkg::func_t'(func) == plst_pkg::FUNC_INSERT && ins_ok) ||
              (plst_pkg::func_t'(func) == plst_pkg::FUNC_DELETE && del_ok)) begin
            state_next = plst_pkg::S_SHIFT;
          end
        end
      end
      plst_pkg::S_SHIFT: begin
        if (left == '0 && !pend) begin
          state_next = plst_pkg::S_FINISH;
        end
      end
      plst_pkg::S_FINISH: state_next = plst_pkg::S_IDLE;
      default:            state_next = plst_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_next     = count;
    is_ins_next    = is_ins;
    rd_addr_next   = rd_addr;
    left_next      = left;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    idx_next       = idx;
    val_next       = val;
    done_next      = 1'b0;
    status_next    = status;
    length_next    = length;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr;
    ram_wdata      = ram_rdata;
    unique case (state)
      plst_pkg::S_IDLE: begin
        if (accept) begin
          status_next = plst_pkg::ST_OK;
          length_next = plst_pkg::LEN_W'(count);
          val_next    = value;
          unique case (plst_pkg::func_t'(func))
            plst_pkg::FUNC_INSERT: begin
              if (ins_ok) begin
                is_ins_next  = 1'b1;
                idx_next     = AW'(ins_idx_x);
                left_next    = CW'(ins_n_x);
                rd_addr_next = AW'(cnt_x - XW'(1));
              end else begin
                done_next   = 1'b1;
                status_next = plst_pkg::ST_FULL;
              end
            end
            plst_pkg::FUNC_DELETE: begin
              if (del_ok) begin
                is_ins_next  = 1'b0;
                left_next    = CW'(del_n_x);
                rd_addr_next = AW'(pos_x);
              end else begin
                done_next   = 1'b1;
                status_next = (count == '0) ? plst_pkg::ST_EMPTY : plst_pkg::ST_NOPOS;
              end
            end
            plst_pkg::FUNC_QUERY: begin
              done_next = 1'b1;
            end
            plst_pkg::FUNC_CLEAR: begin
              done_next   = 1'b1;
              count_next  = '0;
              length_next = '0;
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      plst_pkg::S_SHIFT: begin
        // read data from last cycle lands one slot over
        ram_we = pend;
        if (left != '0) begin
          pend_next      = 1'b1;
          pend_addr_next = is_ins ? rd_addr + AW'(1) : rd_addr - AW'(1);
          rd_addr_next   = is_ins ? rd_addr - AW'(1) : rd_addr + AW'(1);
          left_next      = left - CW'(1);
        end
      end
      plst_pkg::S_FINISH: begin
        ram_we      = is_ins;
        ram_waddr   = idx;
        ram_wdata   = val;
        count_next  = is_ins ? count + CW'(1) : count - CW'(1);
        done_next   = 1'b1;
        status_next = plst_pkg::ST_OK;
        length_next = plst_pkg::LEN_W'(count_next);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plst_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      pend  <= pend_next;
    end
    is_ins    <= is_ins_next;
    rd_addr   <= rd_addr_next;
    left      <= left_next;
    pend_addr <= pend_addr_next;
    idx       <= idx_next;
    val       <= val_next;
    status    <= status_next;
    length    <= length_next;
  end

  plst_ram #(
    .WIDTH (plst_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

endmodule
